/* rtl/wsd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types, constants and helpers for the websocket frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

   // Width of the kept payload length; longer extended lengths wrap.
   localparam int LengthBits = 64;

   localparam logic [6:0] LenCode16      = 7'd126;
   localparam logic [6:0] LenCode64      = 7'd127;
   localparam logic [3:0] ExtLenBytes16  = 4'd2;
   localparam logic [3:0] ExtLenBytes64  = 4'd8;
   localparam logic [2:0] MaskKeyBytes   = 3'd4;

   localparam logic [3:0] OpClose        = 4'h8;
   localparam logic [3:0] OpPing         = 4'h9;

   localparam logic [1:0] ActDeliver     = 2'd0;
   localparam logic [1:0] ActPong        = 2'd1;
   localparam logic [1:0] ActClose       = 2'd2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       payload_valid;
      logic [3:0] opcode;
      logic       frame_end;
      logic [1:0] action;
   } wsd_result_type;

   function automatic logic [1:0] action_of(input logic [3:0] op);
      logic [1:0] act;
      act = ActDeliver;
      if (op == OpPing) begin
         act = ActPong;
      end else if (op == OpClose) begin
         act = ActClose;
      end
      return act;
   endfunction

endpackage

/* rtl/wsd_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_if
// Valid/ready channels of the deframer: received bytes in, results out.
// ----------------------------------------------------------------------------
interface wsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface wsd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       payload_valid;
   logic [3:0] opcode;
   logic       frame_end;
   logic [1:0] action;

   modport source (output valid, output data_byte, output payload_valid, output opcode,
                   output frame_end, output action, input ready);
   modport sink   (input valid, input data_byte, input payload_valid, input opcode,
                   input frame_end, input action, output ready);
endinterface

/* rtl/wsd_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_parser
// Frame header parser and payload unmasker; one byte per accepted word.
// ----------------------------------------------------------------------------
module wsd_parser
   import wsd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           accept,
   input  logic [7:0]     rx_byte,
   output logic           result_valid,
   output wsd_result_type result
);

   typedef enum logic [2:0] {
      PhFirst   = 3'd0,
      PhSecond  = 3'd1,
      PhExtLen  = 3'd2,
      PhKey     = 3'd3,
      PhPayload = 3'd4
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [3:0]            opcode_ff, opcode_in;
   logic                  masked_ff, masked_in;
   logic [3:0]            ext_left_ff, ext_left_in;
   logic [LengthBits-1:0] remaining_ff, remaining_in;
   logic [31:0]           mask_key_ff, mask_key_in;
   logic [2:0]            key_left_ff, key_left_in;
   logic [1:0]            mask_index_ff, mask_index_in;

   logic [LengthBits-1:0] len_shift;
   logic [7:0]            key_byte;

   assign len_shift = {remaining_ff[LengthBits-9:0], rx_byte};

   always_comb begin
      unique case (mask_index_ff)
         2'd0:    key_byte = mask_key_ff[31:24];
         2'd1:    key_byte = mask_key_ff[23:16];
         2'd2:    key_byte = mask_key_ff[15:8];
         default: key_byte = mask_key_ff[7:0];
      endcase
      if (!masked_ff) begin
         key_byte = 8'd0;
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      opcode_in     = opcode_ff;
      masked_in     = masked_ff;
      ext_left_in   = ext_left_ff;
      remaining_in  = remaining_ff;
      mask_key_in   = mask_key_ff;
      key_left_in   = key_left_ff;
      mask_index_in = mask_index_ff;

      result_valid         = 1'b0;
      result.data_byte     = 8'd0;
      result.payload_valid = 1'b0;
      result.opcode        = opcode_ff;
      result.frame_end     = 1'b0;
      result.action        = action_of(opcode_ff);

      unique case (phase_ff)
         PhSecond: begin
            masked_in     = rx_byte[7];
            mask_index_in = 2'd0;
            mask_key_in   = 32'd0;
            remaining_in  = {{(LengthBits-7){1'b0}}, rx_byte[6:0]};
            if (rx_byte[6:0] == LenCode16 || rx_byte[6:0] == LenCode64) begin
               remaining_in = '0;
               ext_left_in  = (rx_byte[6:0] == LenCode16) ? ExtLenBytes16 : ExtLenBytes64;
               phase_in     = PhExtLen;
            end else if (rx_byte[7]) begin
               key_left_in = MaskKeyBytes;
               phase_in    = PhKey;
            end else if (rx_byte[6:0] == 7'd0) begin
               phase_in         = PhFirst;
               result_valid     = 1'b1;
               result.frame_end = 1'b1;
            end else begin
               phase_in = PhPayload;
            end
         end
         PhExtLen: begin
            remaining_in = len_shift;
            ext_left_in  = ext_left_ff - 4'd1;
            if (ext_left_ff == 4'd1) begin
               if (masked_ff) begin
                  key_left_in = MaskKeyBytes;
                  phase_in    = PhKey;
               end else if (len_shift == '0) begin
                  phase_in         = PhFirst;
                  result_valid     = 1'b1;
                  result.frame_end = 1'b1;
               end else begin
                  phase_in = PhPayload;
               end
            end
         end
         PhKey: begin
            mask_key_in = {mask_key_ff[23:0], rx_byte};
            key_left_in = key_left_ff - 3'd1;
            if (key_left_ff == 3'd1) begin
               if (remaining_ff == '0) begin
                  phase_in         = PhFirst;
                  result_valid     = 1'b1;
                  result.frame_end = 1'b1;
               end else begin
                  phase_in = PhPayload;
               end
            end
         end
         PhPayload: begin
            mask_index_in        = mask_index_ff + 2'd1;
            remaining_in         = remaining_ff - {{(LengthBits-1){1'b0}}, 1'b1};
            result_valid         = 1'b1;
            result.data_byte     = rx_byte ^ key_byte;
            result.payload_valid = 1'b1;
            // last payload byte closes the frame
            if (remaining_ff == {{(LengthBits-1){1'b0}}, 1'b1}) begin
               phase_in         = PhFirst;
               result.frame_end = 1'b1;
            end
         end
         default: begin
            // unused codes behave as the first header byte
            opcode_in = rx_byte[3:0];
            phase_in  = PhSecond;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PhFirst;
         opcode_ff     <= 4'd0;
         masked_ff     <= 1'b0;
         ext_left_ff   <= 4'd0;
         remaining_ff  <= '0;
         mask_key_ff   <= 32'd0;
         key_left_ff   <= 3'd0;
         mask_index_ff <= 2'd0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         opcode_ff     <= opcode_in;
         masked_ff     <= masked_in;
         ext_left_ff   <= ext_left_in;
         remaining_ff  <= remaining_in;
         mask_key_ff   <= mask_key_in;
         key_left_ff   <= key_left_in;
         mask_index_ff <= mask_index_in;
      end
   end

endmodule

/* rtl/wsd_out_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_out_stage
// Result register between the parser and the result channel.
// ----------------------------------------------------------------------------
module wsd_out_stage
   import wsd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           load,
   input  logic           result_valid,
   input  wsd_result_type result,
   output logic           can_take,
   input  logic           out_ready,
   output logic           out_valid,
   output wsd_result_type out_result
);

   logic           valid_ff, valid_in;
   wsd_result_type result_ff;

   // free when empty or when the held word leaves this cycle
   assign can_take = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = result_valid;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && result_valid) begin
         result_ff <= result;
      end
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule

/* rtl/websocket_frame_deframer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Parses a received websocket byte stream into unmasked payload results.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ch carries one received stream byte per word (rx_byte). The block
//    takes a word whenever its result register is empty or being drained.
//  - rsp_ch carries one result per payload byte, plus one result with
//    payload_valid low for a frame whose payload is empty. Header bytes
//    that do not complete a header give no result.
//  - A result is on rsp_ch in the cycle after its byte is taken.
//  - Throughput: one byte per cycle unless rsp_ch stalls; header parsing,
//    length tracking and the unmask XOR are combinational on parser state.
//  - action tells the receiver what to do: deliver, answer with a pong
//    (ping frame) or answer close and disconnect (close frame).
//  - Reset (synchronous, active high) returns the parser to expect the
//    first header byte of a frame and empties the result register.
//  - When the receiver stalls, the result is held and req_ch.ready drops
//    until the held word is taken; no byte is lost.
// ----------------------------------------------------------------------------
module websocket_frame_deframer
   import wsd_pkg::*;
(
   input logic      clock,
   input logic      reset,
   wsd_req_if.sink  req_ch,
   wsd_rsp_if.source rsp_ch
);

   logic           accept;
   logic           can_take;
   logic           result_valid;
   wsd_result_type result;
   wsd_result_type out_result;

   // Take a byte only when the result register can hold what it produces.
   assign req_ch.ready = can_take;
   assign accept       = req_ch.valid && can_take;

   // Parse and unmask; the parser state advances on every taken byte.
   wsd_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .rx_byte      (req_ch.rx_byte),
      .result_valid (result_valid),
      .result       (result)
   );

   // Hold the result until the receiver takes it.
   wsd_out_stage u_out (
      .clock        (clock),
      .reset        (reset),
      .load         (accept),
      .result_valid (result_valid),
      .result       (result),
      .can_take     (can_take),
      .out_ready    (rsp_ch.ready),
      .out_valid    (rsp_ch.valid),
      .out_result   (out_result)
   );

   assign rsp_ch.data_byte     = out_result.data_byte;
   assign rsp_ch.payload_valid = out_result.payload_valid;
   assign rsp_ch.opcode        = out_result.opcode;
   assign rsp_ch.frame_end     = out_result.frame_end;
   assign rsp_ch.action        = out_result.action;

endmodule
